/* rtl/core/phdc_pkg.sv */
package phdc_pkg;

  // configuration register map
  typedef enum logic [1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgIndexBits = 2;

  // input action codes
  localparam logic ACT_STEP  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // field widths
  localparam int unsigned ErrBits  = 16;
  localparam int unsigned GainBits = 16;
  localparam int unsigned DutyBits = 15;

  // duty thresholds, unsigned Q7.8 percent
  localparam int DutyHighLimit = 95 * 256;
  localparam int DutyFull      = 100 * 256;
  localparam int DutyLowLimit  = 5 * 256;

endpackage

/* rtl/core/pid_heater_duty_controller.sv */
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+-------------------------------------------
// in      | input     | in_valid_i / in_stall_o   | action_i, error_i
// out     | output    | out_valid_o / out_stall_i | duty_percent_o, full_on_o, full_off_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Three register stages: state update and derivative, gain multiplies, sum and clamp.
// One beat per cycle while out_stall_i is low; a beat passes stage 1 and stage 2 before out_valid_o rises.
// The integral and previous error are updated in the cycle a beat is accepted.
// rst_ni clears gains, integral, previous error and all stage valids.
// A stall only holds the stages that are full; empty stages keep taking beats.
module pid_heater_duty_controller #(
  parameter int unsigned SUM_BITS = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic                                     action_i,
  input  logic signed [phdc_pkg::ErrBits-1:0]      error_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [phdc_pkg::DutyBits-1:0]            duty_percent_o,
  output logic                                     full_on_o,
  output logic                                     full_off_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [phdc_pkg::CfgIndexBits-1:0]        cfg_index_i,
  input  logic [phdc_pkg::GainBits-1:0]            cfg_data_i
);

  localparam int unsigned EB      = phdc_pkg::ErrBits;
  localparam int unsigned GB      = phdc_pkg::GainBits;
  localparam int unsigned LoBits  = SUM_BITS / 2;
  localparam int unsigned HiBits  = SUM_BITS - LoBits;
  localparam int unsigned AccBits = SUM_BITS + 17;
  localparam int unsigned ShBits  = AccBits - 4;

  localparam logic signed [SUM_BITS:0] SumMax = {2'b00, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS:0] SumMin = {2'b11, {(SUM_BITS-1){1'b0}}};

  localparam logic signed [ShBits-1:0] DutyHigh = ShBits'(phdc_pkg::DutyHighLimit);
  localparam logic signed [ShBits-1:0] DutyLow  = ShBits'(phdc_pkg::DutyLowLimit);
  localparam logic [phdc_pkg::DutyBits-1:0] DutyFull =
    phdc_pkg::DutyBits'(phdc_pkg::DutyFull);

  // gains
  logic signed [GB-1:0] kp_q, ki_q, kd_q;

  // controller state
  logic signed [SUM_BITS-1:0] sum_q, sum_d;
  logic signed [EB-1:0]       prev_q, prev_d;
  logic signed [SUM_BITS:0]   sum_ext;

  // stage 1
  logic                s1_valid_q, s1_clr_q;
  logic signed [EB:0]  s1_diff_q, diff_d;

  // stage 2
  logic                         s2_valid_q, s2_clr_q;
  logic signed [2*GB-1:0]       s2_pp_q;
  logic signed [2*GB:0]         s2_pd_q;
  logic signed [GB+HiBits-1:0]  s2_pih_q;
  logic signed [GB+LoBits:0]    s2_pil_q;
  logic signed [HiBits-1:0]     sum_hi;
  logic signed [LoBits:0]       sum_lo;

  // stage 3
  logic                         out_valid_q, full_on_q, full_off_q;
  logic [phdc_pkg::DutyBits-1:0] duty_q;
  logic signed [AccBits-1:0]    acc;
  logic signed [ShBits-1:0]     duty_full_res;
  logic [phdc_pkg::DutyBits-1:0] duty_d;
  logic                         on_d, off_d;

  logic en1, en2, en3, take;

  assign en3  = !out_valid_q || !out_stall_i;
  assign en2  = !s2_valid_q || en3;
  assign en1  = !s1_valid_q || en2;
  assign take = in_valid_i && en1;

  assign in_stall_o  = !en1;
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0;
      ki_q <= '0;
      kd_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        phdc_pkg::REG_GAIN_P: kp_q <= cfg_data_i;
        phdc_pkg::REG_GAIN_I: ki_q <= cfg_data_i;
        phdc_pkg::REG_GAIN_D: kd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // integral with saturation, derivative against the previous error
  always_comb begin
    sum_ext = {sum_q[SUM_BITS-1], sum_q} + {{(SUM_BITS-EB+1){error_i[EB-1]}}, error_i};
    diff_d  = {error_i[EB-1], error_i} - {prev_q[EB-1], prev_q};
    if (action_i == phdc_pkg::ACT_CLEAR) begin
      sum_d  = '0;
      prev_d = '0;
    end else begin
      prev_d = error_i;
      if (sum_ext > SumMax) begin
        sum_d = SumMax[SUM_BITS-1:0];
      end else if (sum_ext < SumMin) begin
        sum_d = SumMin[SUM_BITS-1:0];
      end else begin
        sum_d = sum_ext[SUM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      prev_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_q <= in_valid_i;
      end
      if (take) begin
        sum_q  <= sum_d;
        prev_q <= prev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_clr_q  <= (action_i == phdc_pkg::ACT_CLEAR);
      s1_diff_q <= diff_d;
    end
  end

  // sum_q/prev_q hold the values written by the beat in stage 1 until it moves on
  // ki * sum is split into a signed high half and an unsigned low half
  assign sum_hi = sum_q[SUM_BITS-1:LoBits];
  assign sum_lo = {1'b0, sum_q[LoBits-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      s2_clr_q <= s1_clr_q;
      s2_pp_q  <= kp_q * prev_q;
      s2_pd_q  <= kd_q * s1_diff_q;
      s2_pih_q <= ki_q * sum_hi;
      s2_pil_q <= ki_q * sum_lo;
    end
  end

  // sum of products, floor shift by 4, snap to the rails; a clear beat gives zero duty
  always_comb begin
    acc = AccBits'(s2_pp_q) + AccBits'(s2_pd_q) + (AccBits'(s2_pih_q) <<< LoBits)
        + AccBits'(s2_pil_q);
    duty_full_res = acc[AccBits-1:4];
    on_d   = 1'b0;
    off_d  = 1'b0;
    duty_d = duty_full_res[phdc_pkg::DutyBits-1:0];
    if (s2_clr_q) begin
      duty_d = '0;
    end else if (duty_full_res > DutyHigh) begin
      duty_d = DutyFull;
      on_d   = 1'b1;
    end else if (duty_full_res < DutyLow) begin
      duty_d = '0;
      off_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en3) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && s2_valid_q) begin
      duty_q     <= duty_d;
      full_on_q  <= on_d;
      full_off_q <= off_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign duty_percent_o = duty_q;
  assign full_on_o      = full_on_q;
  assign full_off_o     = full_off_q;

endmodule
